// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file ogfe_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

// File: rtl/core/ogfe_pkg.sv
// Shared constants and types of the occupancy grid footprint engine.
package ogfe_pkg;

  localparam int GRID_SIZE      = 128;
  localparam int GRID_W         = $clog2(GRID_SIZE);
  localparam int COORD_W        = GRID_W + 2;
  localparam int R_MAX          = GRID_SIZE - 1;
  localparam int HW_W           = 3;
  localparam int MAX_HALF_WIDTH = 7;
  localparam int CMD_W          = 3;
  localparam int IN_W           = 24;
  localparam int OUT_W          = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_BLOCK = 3'd0,
    CMD_FREE  = 3'd1,
    CMD_CHECK = 3'd2,
    CMD_FIND  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [GRID_W-1:0] cell_x;
    logic [GRID_W-1:0] cell_y;
    logic [HW_W-1:0]   half_width;
    logic              trimmed_shape;
  } in_item_t;

  typedef struct packed {
    logic              vld;
    logic              ok;
    logic [GRID_W-1:0] found_x;
    logic [GRID_W-1:0] found_y;
  } res_t;

  typedef struct packed {
    logic                 rd_en;
    logic [GRID_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [GRID_W-1:0]    wr_addr;
    logic [GRID_SIZE-1:0] wr_data;
  } map_req_t;

endpackage

// File: rtl/core/ogfe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module ogfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/ogfe_map.sv
// Row-organised passable map: row RAM plus per-row valid bits (unwritten rows read all free).
module ogfe_map import ogfe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  map_req_t             req,
  output logic [GRID_SIZE-1:0] rd_data
);

  logic [GRID_SIZE-1:0] valid_r;
  logic                 vq_r;
  logic [GRID_SIZE-1:0] ram_q;

  ogfe_ram #(.WIDTH(GRID_SIZE), .DEPTH(GRID_SIZE)) u_ram (
    .clk     (clk),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr),
    .rd_data (ram_q),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (req.wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
    if (req.rd_en) begin
      vq_r <= valid_r[req.rd_addr];
    end
  end

  assign rd_data = vq_r ? ram_q : '1;

endmodule

// File: rtl/core/ogfe_seq.sv
// Command sequencer: row read-modify-write for marking, row reads for checks, ring walk for search.
module ogfe_seq import ogfe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  in_item_t             item,
  output logic                 busy,
  input  logic                 res_hold,
  output res_t                 res,
  output map_req_t             req,
  input  logic [GRID_SIZE-1:0] rd_data
);

  typedef enum logic [2:0] {S_IDLE, S_ROWS, S_RDRAIN, S_FIND, S_FDRAIN, S_RES} state_t;

  state_t                     state_r, state_nxt;
  logic [CMD_W-1:0]           op_r, op_nxt;
  logic [GRID_W-1:0]          x_r, x_nxt, y_r, y_nxt;
  logic [GRID_SIZE-1:0]       mask_r, mask_nxt;
  logic [GRID_W-1:0]          row_r, row_nxt, row_hi_r, row_hi_nxt;
  logic                       fail_r, fail_nxt;
  logic                       p_vld_r, p_vld_nxt;
  logic [GRID_W-1:0]          p_row_r, p_row_nxt;
  logic [GRID_W-1:0]          rad_r, rad_nxt;
  logic signed [COORD_W-1:0]  dx_r, dx_nxt;
  logic                       side_r, side_nxt;
  logic                       c_vld_r, c_vld_nxt;
  logic [GRID_W-1:0]          c_x_r, c_x_nxt, c_y_r, c_y_nxt;
  logic                       ok_r, ok_nxt;
  logic [GRID_W-1:0]          fx_r, fx_nxt, fy_r, fy_nxt;
  logic                       rv_r, rv_nxt;

  logic [HW_W-1:0]            hw_eff;
  logic signed [COORD_W-1:0]  xs, ys, hwv, tv, xlo, xhi, ylo, yhi, ylo_c, yhi_c, iv;
  logic signed [COORD_W-1:0]  adx, cx, cy, dyv;
  logic [GRID_W-1:0]          dy;
  logic                       inb_sq, cand_in, hit;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    mask_nxt   = mask_r;
    row_nxt    = row_r;
    row_hi_nxt = row_hi_r;
    fail_nxt   = fail_r;
    p_vld_nxt  = 1'b0;
    p_row_nxt  = p_row_r;
    rad_nxt    = rad_r;
    dx_nxt     = dx_r;
    side_nxt   = side_r;
    c_vld_nxt  = 1'b0;
    c_x_nxt    = c_x_r;
    c_y_nxt    = c_y_r;
    ok_nxt     = ok_r;
    fx_nxt     = fx_r;
    fy_nxt     = fy_r;
    rv_nxt     = 1'b0;
    req        = '0;
    iv         = '0;

    // footprint geometry of the incoming item
    hw_eff = (item.half_width > HW_W'(MAX_HALF_WIDTH)) ? HW_W'(MAX_HALF_WIDTH)
                                                      : item.half_width;
    if (item.cmd == CMD_READ) begin
      hw_eff = '0;
    end
    xs  = $signed(COORD_W'(item.cell_x));
    ys  = $signed(COORD_W'(item.cell_y));
    hwv = $signed(COORD_W'(hw_eff));
    tv  = $signed(COORD_W'(((item.cmd == CMD_BLOCK) || (item.cmd == CMD_FREE))
                           && item.trimmed_shape));
    xlo = xs - hwv;
    xhi = xs + hwv;
    ylo = ys - hwv + tv;
    yhi = ys + hwv - tv;
    ylo_c = ylo[COORD_W-1] ? '0 : ylo;
    yhi_c = (yhi > $signed(COORD_W'(R_MAX))) ? $signed(COORD_W'(R_MAX)) : yhi;
    inb_sq = !xlo[COORD_W-1] && !ylo[COORD_W-1] &&
             (xhi <= $signed(COORD_W'(R_MAX))) && (yhi <= $signed(COORD_W'(R_MAX)));

    // ring walk candidate
    adx = dx_r[COORD_W-1] ? -dx_r : dx_r;
    dy  = rad_r - adx[GRID_W-1:0];
    dyv = $signed(COORD_W'(dy));
    cx  = $signed(COORD_W'(x_r)) + dx_r;
    cy  = side_r ? ($signed(COORD_W'(y_r)) - dyv) : ($signed(COORD_W'(y_r)) + dyv);
    cand_in = !cx[COORD_W-1] && !cy[COORD_W-1] &&
              (cx <= $signed(COORD_W'(R_MAX))) && (cy <= $signed(COORD_W'(R_MAX)));
    hit = c_vld_r && rd_data[c_x_r];

    // row write-back or row check, in the cycle after the read
    if (p_vld_r) begin
      if ((op_r == CMD_BLOCK) || (op_r == CMD_FREE)) begin
        req.wr_en   = 1'b1;
        req.wr_addr = p_row_r;
        req.wr_data = (op_r == CMD_BLOCK) ? (rd_data & ~mask_r) : (rd_data | mask_r);
      end else if ((rd_data & mask_r) != mask_r) begin
        fail_nxt = 1'b1;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = item.cmd;
          x_nxt    = item.cell_x;
          y_nxt    = item.cell_y;
          ok_nxt   = 1'b0;
          fx_nxt   = '0;
          fy_nxt   = '0;
          fail_nxt = 1'b0;
          for (int i = 0; i < GRID_SIZE; i++) begin
            iv = $signed(COORD_W'(i));
            mask_nxt[i] = (iv >= xlo) && (iv <= xhi);
          end
          row_nxt    = ylo_c[GRID_W-1:0];
          row_hi_nxt = yhi_c[GRID_W-1:0];
          rad_nxt    = '0;
          dx_nxt     = '0;
          side_nxt   = 1'b0;
          case (item.cmd) inside
            CMD_BLOCK, CMD_FREE: state_nxt = (ylo_c > yhi_c) ? S_RES : S_ROWS;
            CMD_CHECK, CMD_READ: state_nxt = inb_sq ? S_ROWS : S_RES;
            CMD_FIND:            state_nxt = S_FIND;
            default:             state_nxt = S_RES;
          endcase
        end
      end
      S_ROWS: begin
        req.rd_en   = 1'b1;
        req.rd_addr = row_r;
        p_vld_nxt   = 1'b1;
        p_row_nxt   = row_r;
        if (row_r == row_hi_r) begin
          state_nxt = S_RDRAIN;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
      S_RDRAIN: begin
        ok_nxt    = ((op_r == CMD_CHECK) || (op_r == CMD_READ)) && !fail_nxt;
        state_nxt = S_RES;
      end
      S_FIND: begin
        if (hit) begin
          ok_nxt    = 1'b1;
          fx_nxt    = c_x_r;
          fy_nxt    = c_y_r;
          state_nxt = S_RES;
        end else begin
          req.rd_en   = cand_in;
          req.rd_addr = cy[GRID_W-1:0];
          c_vld_nxt   = cand_in;
          c_x_nxt     = cx[GRID_W-1:0];
          c_y_nxt     = cy[GRID_W-1:0];
          side_nxt    = !side_r;
          if (side_r) begin
            if (dx_r == $signed(COORD_W'(rad_r))) begin
              if (rad_r == GRID_W'(R_MAX)) begin
                state_nxt = S_FDRAIN;
              end else begin
                rad_nxt = rad_r + 1'b1;
                dx_nxt  = -$signed(COORD_W'(rad_r + 1'b1));
              end
            end else begin
              dx_nxt = dx_r + 1'b1;
            end
          end
        end
      end
      S_FDRAIN: begin
        if (hit) begin
          ok_nxt = 1'b1;
          fx_nxt = c_x_r;
          fy_nxt = c_y_r;
        end
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!res_hold) begin
          rv_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      p_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_vld_r <= p_vld_nxt;
      c_vld_r <= c_vld_nxt;
      rv_r    <= rv_nxt;
    end
    op_r     <= op_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    mask_r   <= mask_nxt;
    row_r    <= row_nxt;
    row_hi_r <= row_hi_nxt;
    fail_r   <= fail_nxt;
    p_row_r  <= p_row_nxt;
    rad_r    <= rad_nxt;
    dx_r     <= dx_nxt;
    side_r   <= side_nxt;
    c_x_r    <= c_x_nxt;
    c_y_r    <= c_y_nxt;
    ok_r     <= ok_nxt;
    fx_r     <= fx_nxt;
    fy_r     <= fy_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign res  = {rv_r, ok_r, fx_r, fy_r};

endmodule

// File: rtl/core/occupancy_grid_footprint_engine.sv
// Occupancy grid footprint engine: top level with stream ports and output register.
// One item at a time; ready is high whenever no command is in progress, also while a
// result waits in the output register. The map is a 128-row RAM of 128-bit rows,
// one row read per cycle. Mark and check read the footprint rows one per cycle; a read
// cell reads one row; a failed-bounds check or unknown command reads none. Nearest-free
// search tests one candidate cell per cycle in ring order until it hits a free cell or
// has walked its last ring. No clearing pass is needed after reset.
module occupancy_grid_footprint_engine import ogfe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // cmd, cell_x, cell_y, half_width, trimmed_shape
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // ok, found_x, found_y
);

  in_item_t             item;
  res_t                 res;
  map_req_t             req;
  logic [GRID_SIZE-1:0] rd_data;
  logic                 busy;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]     out_tdata_r, out_tdata_nxt;

  assign item = {in_tdata[2:0], in_tdata[9:3], in_tdata[16:10], in_tdata[19:17],
                 in_tdata[20]};

  assign in_tready = !busy;

  ogfe_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_tvalid && in_tready),
    .item     (item),
    .busy     (busy),
    .res_hold (out_tvalid_r && !out_tready),
    .res      (res),
    .req      (req),
    .rd_data  (rd_data)
  );

  ogfe_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    if (res.vld) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {1'b0, res.found_y, res.found_x, res.ok};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// File: rtl/core/ogfe_checker.sv
// Port-level checks of the occupancy grid footprint engine, bound to the top level.
`include "assert_macros.svh"
module ogfe_checker import ogfe_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `ASSERT_CLK(a_pad_zero, clk, rst_n, out_tvalid |-> out_tdata[OUT_W-1] == 1'b0)
  `ASSERT_CLK(a_miss_zero, clk, rst_n, out_tvalid && !out_tdata[0] |-> out_tdata[14:1] == 14'd0)
  `ASSERT_CLK(a_busy_after_take, clk, rst_n, in_tvalid && in_tready |=> !in_tready)
  `ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_tvalid && in_tready)

endmodule

bind occupancy_grid_footprint_engine ogfe_checker u_ogfe_checker (.*);

// File: tb/tb_occupancy_grid_footprint_engine.sv
// Self-checking testbench for the occupancy grid footprint engine.
module tb_occupancy_grid_footprint_engine;
  import ogfe_pkg::*;

  typedef struct packed {
    logic       ok;
    logic [6:0] fx;
    logic [6:0] fy;
  } grid_res_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  logic [IN_W-1:0] cmd_q[$];
  grid_res_t       res_q[$];
  bit              grid_free[GRID_SIZE][GRID_SIZE];
  int              errors = 0;
  int              in_gap = 0;
  int              out_gap = 0;
  bit              hold_rx = 1'b0;
  bit              calm = 1'b0;
  bit              driving = 1'b0;

  occupancy_grid_footprint_engine u_top (.*);

  always #4 clk = ~clk;

  function automatic bit free_at(int x, int y);
    if (x < 0 || y < 0 || x >= GRID_SIZE || y >= GRID_SIZE) return 1'b0;
    return grid_free[x][y];
  endfunction

  function automatic grid_res_t apply_cmd(logic [IN_W-1:0] d);
    grid_res_t r;
    int c, x, y, hw, t, dy;
    bit done;
    r = '0;
    c = d[2:0];
    x = d[9:3];
    y = d[16:10];
    hw = d[19:17];
    t = d[20];
    done = 1'b0;
    if (c == CMD_BLOCK || c == CMD_FREE) begin
      for (int i = x - hw; i <= x + hw; i++)
        for (int j = y - hw + t; j <= y + hw - t; j++)
          if (i >= 0 && j >= 0 && i < GRID_SIZE && j < GRID_SIZE)
            grid_free[i][j] = (c == CMD_FREE);
    end else if (c == CMD_CHECK) begin
      r.ok = 1'b1;
      for (int i = x - hw; i <= x + hw; i++)
        for (int j = y - hw; j <= y + hw; j++)
          if (!free_at(i, j)) r.ok = 1'b0;
    end else if (c == CMD_READ) begin
      r.ok = free_at(x, y);
    end else if (c == CMD_FIND) begin
      if (free_at(x, y)) begin
        r = {1'b1, 7'(x), 7'(y)};
        done = 1'b1;
      end
      for (int rad = 1; rad < GRID_SIZE && !done; rad++)
        for (int dx = -rad; dx <= rad && !done; dx++) begin
          dy = rad - (dx < 0 ? -dx : dx);
          if (free_at(x + dx, y + dy)) begin
            r = {1'b1, 7'(x + dx), 7'(y + dy)};
            done = 1'b1;
          end else if (free_at(x + dx, y - dy)) begin
            r = {1'b1, 7'(x + dx), 7'(y - dy)};
            done = 1'b1;
          end
        end
    end
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_cmd(int c, int x, int y, int hw, int t);
    return {3'b0, 1'(t), 3'(hw), 7'(y), 7'(x), 3'(c)};
  endfunction

  task automatic enqueue(logic [IN_W-1:0] d);
    cmd_q = {cmd_q, d};
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!(in_tvalid && !in_tready)) begin
        if (in_tvalid && in_tready) res_q = {res_q, apply_cmd(in_tdata)};
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0 && driving) begin
          in_tdata <= cmd_q.pop_front();
          in_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 18);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    grid_res_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[7:1], out_tdata[14:8]};
        if (res_q.size() == 0) begin
          $error("unexpected result %h", got);
          errors++;
        end else begin
          want = res_q.pop_front();
          if (got.ok !== want.ok) begin
            $error("ok exp %0d got %0d", want.ok, got.ok);
            errors++;
          end
          if (got.fx !== want.fx) begin
            $error("found_x exp %0d got %0d", want.fx, got.fx);
            errors++;
          end
          if (got.fy !== want.fy) begin
            $error("found_y exp %0d got %0d", want.fy, got.fy);
            errors++;
          end
        end
      end
      if (hold_rx) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 18);
      end
    end
  end

  task automatic add_random(int n);
    int c, x, y;
    for (int k = 0; k < n; k++) begin
      c = $urandom_range(0, 99);
      // mostly cells in a corner region so searches stay short
      x = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 15);
      y = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 15);
      enqueue(pack_cmd(c < 30 ? CMD_BLOCK : c < 45 ? CMD_FREE : c < 65 ? CMD_CHECK :
                       c < 80 ? CMD_FIND : c < 96 ? CMD_READ : $urandom_range(5, 7),
                       x, y, $urandom_range(0, 7), $urandom_range(0, 1)));
    end
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || in_tvalid || res_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < GRID_SIZE; i++)
      for (int j = 0; j < GRID_SIZE; j++) grid_free[i][j] = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    driving = 1'b1;
    enqueue(pack_cmd(CMD_FIND, 0, 0, 0, 0));
    enqueue(pack_cmd(CMD_CHECK, 0, 0, 7, 1));
    enqueue(pack_cmd(CMD_CHECK, 64, 64, 7, 0));
    enqueue(pack_cmd(CMD_BLOCK, 127, 127, 7, 0));
    enqueue(pack_cmd(CMD_READ, 127, 127, 0, 0));
    enqueue(pack_cmd(CMD_FIND, 127, 127, 0, 0));
    enqueue(pack_cmd(CMD_BLOCK, 0, 0, 0, 1));
    enqueue(pack_cmd(CMD_READ, 0, 0, 0, 0));
    enqueue(pack_cmd(CMD_BLOCK, 10, 10, 3, 1));
    enqueue(pack_cmd(CMD_READ, 10, 7, 0, 0));
    enqueue(pack_cmd(CMD_READ, 10, 8, 0, 0));
    enqueue(pack_cmd(CMD_FIND, 10, 10, 0, 0));
    enqueue(pack_cmd(CMD_CHECK, 10, 10, 1, 0));
    enqueue(pack_cmd(CMD_FREE, 10, 10, 3, 0));
    enqueue(pack_cmd(CMD_CHECK, 10, 10, 3, 0));
    enqueue(pack_cmd(5, 127, 0, 7, 1));
    enqueue(pack_cmd(6, 0, 127, 0, 0));
    enqueue(pack_cmd(7, 85, 42, 5, 1));
    enqueue(pack_cmd(CMD_FIND, 0, 127, 0, 0));
    drain();
    // receiver stalls long while the sender keeps offering
    add_random(40);
    fork
      begin
        hold_rx = 1'b1;
        repeat (2000) @(posedge clk);
        hold_rx = 1'b0;
      end
    join_none
    drain();
    add_random(1600);
    drain();
    calm = 1'b1;
    add_random(150);
    drain();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #400000000;
    $display("FAIL");
    $finish;
  end
endmodule
